FILE: hdl/message_fifo_with_abort_and_purge_unit_assert.svh
// Assertion macros for the message FIFO with abort and purge.
// Relies on a clock named clock and a synchronous reset named reset in the including module.
`ifndef MESSAGE_FIFO_WITH_ABORT_AND_PURGE_UNIT_ASSERT_SVH
`define MESSAGE_FIFO_WITH_ABORT_AND_PURGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MFAP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MFAP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define MFAP_ASSERT(lbl, prop, msg)
`define MFAP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/mfap_pkg.sv
// Shared types and constants for the message FIFO with abort and purge.
// No dependencies; the controller, datapath and top refer to it by scoped names.
package mfap_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_FLUSH_CODE = '0;

   typedef enum logic [2:0] {
      CMD_PUT    = 3'd0,
      CMD_GET    = 3'd1,
      CMD_FLUSH  = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_ABORT  = 3'd4,
      CMD_START  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_ABORTED = 3'd2,
      ST_FULL    = 3'd3,
      ST_PENDING = 3'd4
   } status_type;

   typedef enum logic {
      KIND_ACK     = 1'b0,
      KIND_DELIVER = 1'b1
   } reply_kind_type;

   typedef enum logic [1:0] {
      SRC_NONE  = 2'd0,
      SRC_RAM   = 2'd1,
      SRC_REQ   = 2'd2,
      SRC_FLUSH = 2'd3
   } msg_src_type;

   typedef enum logic [2:0] {
      S_IDLE         = 3'd0,
      S_DECODE       = 3'd1,
      S_GET_READ     = 3'd2,
      S_REMOVE       = 3'd3,
      S_EMIT_ACK     = 3'd4,
      S_EMIT_DELIVER = 3'd5
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [15:0]        msg_code;
      logic signed [31:0] first_arg;
      logic signed [31:0] second_arg;
      logic               wait_if_empty;
   } req_type;

   typedef struct packed {
      logic               reply_kind;
      logic [2:0]         status;
      logic [15:0]        msg_code_out;
      logic signed [31:0] first_arg_out;
      logic signed [31:0] second_arg_out;
      logic [6:0]         queued_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] code;
      logic [31:0] first;
      logic [31:0] second;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic           load_req;
      logic           read_head;
      logic           push;
      logic           pop;
      logic           flush;
      logic           rm_start;
      logic           set_abort;
      logic           clr_abort;
      logic           set_wait;
      logic           clr_wait;
      logic           emit;
      reply_kind_type emit_kind;
      status_type     emit_status;
      msg_src_type    emit_src;
      logic           emit_last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] cmd;
      logic       wait_if_empty;
      logic       aborted;
      logic       waiting;
      logic       empty;
      logic       full;
      logic       rm_busy;
      logic       out_free;
   } dp_status_type;

endpackage

FILE: hdl/mfap_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mfap_ctrl.sv
// Command sequencer of the message FIFO: decodes each transaction and drives the datapath.
// Depends on mfap_pkg.
module mfap_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mfap_pkg::dp_status_type status,
   output mfap_pkg::dp_cmd_type    cmd
);

   mfap_pkg::state_type   state_ff, state_in;
   mfap_pkg::status_type  ack_status_ff, ack_status_in;
   logic                  ack_ram_ff, ack_ram_in;
   logic                  deliver_ff, deliver_in;
   mfap_pkg::status_type  dlv_status_ff, dlv_status_in;
   mfap_pkg::msg_src_type dlv_src_ff, dlv_src_in;

   assign req_stall = (state_ff != mfap_pkg::S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfap_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = mfap_pkg::S_DECODE;
            end
         end
         mfap_pkg::S_DECODE: begin
            state_in = mfap_pkg::S_EMIT_ACK;
            if (status.cmd == mfap_pkg::CMD_GET && !status.aborted && !status.waiting) begin
               if (!status.empty) begin
                  state_in = mfap_pkg::S_GET_READ;
               end else if (status.wait_if_empty) begin
                  state_in = mfap_pkg::S_IDLE;
               end
            end else if (status.cmd == mfap_pkg::CMD_REMOVE && !status.aborted &&
                         !status.empty) begin
               state_in = mfap_pkg::S_REMOVE;
            end
         end
         mfap_pkg::S_GET_READ: begin
            state_in = mfap_pkg::S_EMIT_ACK;
         end
         mfap_pkg::S_REMOVE: begin
            if (!status.rm_busy) begin
               state_in = mfap_pkg::S_EMIT_ACK;
            end
         end
         mfap_pkg::S_EMIT_ACK: begin
            if (status.out_free) begin
               if (deliver_ff) begin
                  state_in = mfap_pkg::S_EMIT_DELIVER;
               end else begin
                  state_in = mfap_pkg::S_IDLE;
               end
            end
         end
         mfap_pkg::S_EMIT_DELIVER: begin
            if (status.out_free) begin
               state_in = mfap_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mfap_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and decision registers
   always_comb begin
      cmd           = '0;
      ack_status_in = ack_status_ff;
      ack_ram_in    = ack_ram_ff;
      deliver_in    = deliver_ff;
      dlv_status_in = dlv_status_ff;
      dlv_src_in    = dlv_src_ff;
      case (state_ff)
         mfap_pkg::S_IDLE: begin
            cmd.load_req = req_valid;
         end
         mfap_pkg::S_DECODE: begin
            ack_status_in = mfap_pkg::ST_OK;
            ack_ram_in    = 1'b0;
            deliver_in    = 1'b0;
            dlv_status_in = mfap_pkg::ST_OK;
            dlv_src_in    = mfap_pkg::SRC_NONE;
            case (status.cmd)
               mfap_pkg::CMD_PUT, mfap_pkg::CMD_START: begin
                  if (status.cmd == mfap_pkg::CMD_START) begin
                     cmd.clr_abort = 1'b1;
                  end
                  if (status.cmd == mfap_pkg::CMD_PUT && status.aborted) begin
                     ack_status_in = mfap_pkg::ST_ABORTED;
                  end else if (status.waiting) begin
                     // hand the message straight to the parked get
                     cmd.clr_wait = 1'b1;
                     deliver_in   = 1'b1;
                     if (status.cmd == mfap_pkg::CMD_START) begin
                        dlv_src_in = mfap_pkg::SRC_FLUSH;
                     end else begin
                        dlv_src_in = mfap_pkg::SRC_REQ;
                     end
                  end else if (status.full) begin
                     ack_status_in = mfap_pkg::ST_FULL;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               mfap_pkg::CMD_GET: begin
                  if (status.aborted) begin
                     ack_status_in = mfap_pkg::ST_ABORTED;
                  end else if (status.waiting) begin
                     ack_status_in = mfap_pkg::ST_PENDING;
                  end else if (!status.empty) begin
                     cmd.read_head = 1'b1;
                     ack_ram_in    = 1'b1;
                  end else if (status.wait_if_empty) begin
                     cmd.set_wait = 1'b1;
                  end else begin
                     ack_status_in = mfap_pkg::ST_EMPTY;
                  end
               end
               mfap_pkg::CMD_FLUSH: begin
                  cmd.flush = 1'b1;
               end
               mfap_pkg::CMD_REMOVE: begin
                  cmd.rm_start = !status.aborted && !status.empty;
               end
               mfap_pkg::CMD_ABORT: begin
                  cmd.set_abort = 1'b1;
                  if (status.waiting) begin
                     cmd.clr_wait  = 1'b1;
                     deliver_in    = 1'b1;
                     dlv_status_in = mfap_pkg::ST_ABORTED;
                  end
               end
               default: begin
               end
            endcase
         end
         mfap_pkg::S_GET_READ: begin
            cmd.pop = 1'b1;
         end
         mfap_pkg::S_EMIT_ACK: begin
            cmd.emit        = status.out_free;
            cmd.emit_kind   = mfap_pkg::KIND_ACK;
            cmd.emit_status = ack_status_ff;
            cmd.emit_last   = !deliver_ff;
            if (ack_ram_ff) begin
               cmd.emit_src = mfap_pkg::SRC_RAM;
            end else begin
               cmd.emit_src = mfap_pkg::SRC_NONE;
            end
         end
         mfap_pkg::S_EMIT_DELIVER: begin
            cmd.emit        = status.out_free;
            cmd.emit_kind   = mfap_pkg::KIND_DELIVER;
            cmd.emit_status = dlv_status_ff;
            cmd.emit_src    = dlv_src_ff;
            cmd.emit_last   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfap_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_status_ff <= ack_status_in;
      ack_ram_ff    <= ack_ram_in;
      deliver_ff    <= deliver_in;
      dlv_status_ff <= dlv_status_in;
      dlv_src_ff    <= dlv_src_in;
   end

endmodule

FILE: hdl/mfap_datapath.sv
// Datapath of the message FIFO: message RAM, pointers, flags, purge walker, result register.
// Depends on mfap_pkg, mfap_ram and the assertion macro header.
`include "message_fifo_with_abort_and_purge_unit_assert.svh"
module mfap_datapath #(
   parameter int DEPTH = mfap_pkg::DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mfap_pkg::req_type       req_data,
   input  logic [15:0]             flush_code,
   input  mfap_pkg::dp_cmd_type    cmd,
   output mfap_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mfap_pkg::rsp_type       rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ENT_W = $bits(mfap_pkg::entry_type);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

   mfap_pkg::req_type   req_ff, req_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                aborted_ff, aborted_in;
   logic                waiting_ff, waiting_in;
   logic                rm_busy_ff, rm_busy_in;
   logic [IDX_W-1:0]    rm_rd_ff, rm_rd_in;
   logic [IDX_W-1:0]    rm_wr_ff, rm_wr_in;
   logic [CNT_W-1:0]    rm_left_ff, rm_left_in;
   logic [CNT_W-1:0]    rm_kept_ff, rm_kept_in;
   logic                rm_pend_ff, rm_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mfap_pkg::rsp_type   rsp_ff, rsp_in;

   logic                rm_issue, rm_keep, rm_done, out_free;
   mfap_pkg::entry_type push_entry, ram_q, ram_wdata, msg_sel;
   logic                ram_we, ram_re;
   logic [IDX_W-1:0]    ram_waddr, ram_raddr;
   logic [CNT_W+6:0]    count_ext;

   mfap_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // purge walker: read one entry a cycle, write back the survivors one behind
   assign rm_issue = rm_busy_ff && (rm_left_ff != '0);
   assign rm_keep  = rm_busy_ff && rm_pend_ff && (ram_q.code != req_ff.msg_code);
   assign rm_done  = rm_busy_ff && (rm_left_ff == '0) && !rm_pend_ff;

   always_comb begin
      if (req_ff.cmd == mfap_pkg::CMD_START) begin
         push_entry.code   = flush_code;
         push_entry.first  = '0;
         push_entry.second = '0;
      end else begin
         push_entry.code   = req_ff.msg_code;
         push_entry.first  = req_ff.first_arg;
         push_entry.second = req_ff.second_arg;
      end
   end

   assign ram_we    = cmd.push || rm_keep;
   assign ram_waddr = rm_keep ? rm_wr_ff : tail_ff;
   assign ram_wdata = rm_keep ? ram_q : push_entry;
   assign ram_re    = cmd.read_head || rm_issue;
   assign ram_raddr = rm_busy_ff ? rm_rd_ff : head_ff;

   always_comb begin
      case (cmd.emit_src)
         mfap_pkg::SRC_RAM: begin
            msg_sel = ram_q;
         end
         mfap_pkg::SRC_REQ: begin
            msg_sel.code   = req_ff.msg_code;
            msg_sel.first  = req_ff.first_arg;
            msg_sel.second = req_ff.second_arg;
         end
         mfap_pkg::SRC_FLUSH: begin
            msg_sel.code   = flush_code;
            msg_sel.first  = '0;
            msg_sel.second = '0;
         end
         default: begin
            msg_sel = '0;
         end
      endcase
   end

   assign count_ext = {7'd0, count_ff};

   always_comb begin
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      aborted_in   = aborted_ff;
      waiting_in   = waiting_ff;
      rm_busy_in   = rm_busy_ff;
      rm_rd_in     = rm_rd_ff;
      rm_wr_in     = rm_wr_ff;
      rm_left_in   = rm_left_ff;
      rm_kept_in   = rm_kept_ff;
      rm_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.load_req) begin
         req_in = req_data;
      end

      if (cmd.flush) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
      if (cmd.push) begin
         tail_in  = next_idx(tail_ff);
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         head_in  = next_idx(head_ff);
         count_in = count_ff - 1'b1;
      end

      if (cmd.set_abort) begin
         aborted_in = 1'b1;
      end
      if (cmd.clr_abort) begin
         aborted_in = 1'b0;
      end
      if (cmd.set_wait) begin
         waiting_in = 1'b1;
      end
      if (cmd.clr_wait) begin
         waiting_in = 1'b0;
      end

      if (cmd.rm_start) begin
         rm_busy_in = 1'b1;
         rm_rd_in   = head_ff;
         rm_wr_in   = head_ff;
         rm_left_in = count_ff;
         rm_kept_in = '0;
      end
      if (rm_issue) begin
         rm_rd_in   = next_idx(rm_rd_ff);
         rm_left_in = rm_left_ff - 1'b1;
         rm_pend_in = 1'b1;
      end
      if (rm_keep) begin
         rm_wr_in   = next_idx(rm_wr_ff);
         rm_kept_in = rm_kept_ff + 1'b1;
      end
      if (rm_done) begin
         rm_busy_in = 1'b0;
         count_in   = rm_kept_ff;
         tail_in    = rm_wr_ff;
      end

      // result register: load on emit, drop once taken
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.reply_kind     = cmd.emit_kind;
         rsp_in.status         = cmd.emit_status;
         rsp_in.msg_code_out   = msg_sel.code;
         rsp_in.first_arg_out  = msg_sel.first;
         rsp_in.second_arg_out = msg_sel.second;
         rsp_in.queued_count   = count_ext[6:0];
         rsp_in.last           = cmd.emit_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         aborted_ff   <= 1'b1;
         waiting_ff   <= 1'b0;
         rm_busy_ff   <= 1'b0;
         rm_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         aborted_ff   <= aborted_in;
         waiting_ff   <= waiting_in;
         rm_busy_ff   <= rm_busy_in;
         rm_pend_ff   <= rm_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rm_rd_ff   <= rm_rd_in;
      rm_wr_ff   <= rm_wr_in;
      rm_left_ff <= rm_left_in;
      rm_kept_ff <= rm_kept_in;
      rsp_ff     <= rsp_in;
   end

   assign status.cmd           = req_ff.cmd;
   assign status.wait_if_empty = req_ff.wait_if_empty;
   assign status.aborted       = aborted_ff;
   assign status.waiting       = waiting_ff;
   assign status.empty         = (count_ff == '0);
   assign status.full          = (count_ff == CNT_W'(DEPTH));
   assign status.rm_busy       = rm_busy_ff;
   assign status.out_free      = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MFAP_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "held count exceeds depth")
   `MFAP_ASSERT(a_empty_ptrs, (count_ff == '0 && !rm_busy_ff) |-> (head_ff == tail_ff), "empty queue with split pointers")
   `MFAP_ASSERT(a_no_push_in_purge, !(cmd.push && rm_busy_ff), "push during purge walk")
   `MFAP_ASSERT(a_emit_slot_free, cmd.emit |-> out_free, "result overwrites an untaken result")
   `MFAP_ASSERT_NEXT(a_purge_shrinks, rm_done, count_ff <= $past(count_ff), "purge grew the queue")

endmodule

FILE: hdl/message_fifo_with_abort_and_purge_unit.sv
// Top level of the message FIFO with abort and purge: channels, CSR and the two halves.
// Depends on mfap_pkg, mfap_ctrl, mfap_datapath (and through it mfap_ram).
//
// Usage:
//  - req channel carries one command transaction (put, get, flush, remove code, abort, start)
//    with a message code, two signed arguments and a wait flag. It is taken on a rising edge
//    with req_valid high and req_stall low.
//  - rsp channel returns zero, one or two result transactions per command; the final one has
//    last set. A get with the wait flag on an empty open queue, none parked, returns nothing;
//    the following put or start delivers to it, and an abort releases it with status aborted.
//  - After acceptance a command passes the decode state and then the ack emit state, which
//    loads the result register; a get that dequeues reads the RAM in a state in between, a
//    remove walks the queue first, reading one entry per cycle, and a delivery follows the ack.
//  - A new command is taken only once the controller is back in idle, after its last result
//    went into the result register; the controller does not overlap commands.
//  - Reset leaves the queue empty and aborted, no get pending, flush code zero. The message
//    RAM is not cleared; only written entries are ever read.
//  - When rsp_stall holds a result, the result register keeps it; the next command is still
//    accepted and decoded, then waits for the register before emitting.
//  - flush_code sits at byte address 0 of the APB-style port; write it only while idle.
module message_fifo_with_abort_and_purge_unit #(
   parameter int DEPTH = mfap_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mfap_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mfap_pkg::rsp_type               rsp_data,
   // configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mfap_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mfap_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mfap_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   mfap_pkg::dp_cmd_type    dp_cmd;
   mfap_pkg::dp_status_type dp_status;

   logic [15:0] flush_code_ff, flush_code_in;
   logic        csr_hit;
   logic        csr_wr;

   // CSR decode: word index from the upper address bits, zero wait states
   assign pready  = 1'b1;
   assign csr_hit = (paddr[mfap_pkg::CSR_ADDR_W-1:2] == mfap_pkg::CSR_IDX_FLUSH_CODE);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;

   always_comb begin
      flush_code_in = flush_code_ff;
      if (csr_wr) begin
         flush_code_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_code_ff <= '0;
      end else begin
         flush_code_ff <= flush_code_in;
      end
   end

   // reads return the register, zero elsewhere
   assign prdata = csr_hit ? {{(mfap_pkg::CSR_DATA_W - 16){1'b0}}, flush_code_ff} : '0;

   // sequencer: owns the state machine and the per-command decisions
   mfap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // storage, pointers, flags, purge walker and result register
   mfap_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .flush_code (flush_code_ff),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: bench/message_fifo_with_abort_and_purge_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for message_fifo_with_abort_and_purge_unit: random and directed commands,
// checked against a transaction-level model of the message queue kept in this file.
// Depends on mfap_pkg for the channel structs, command, status and reply-kind codes.
module message_fifo_with_abort_and_purge_unit_tb;
   import mfap_pkg::*;

   localparam int QUEUE_DEPTH    = DEPTH_DEFAULT;
   localparam int RESET_CYCLES   = 6;
   // remove walks the whole queue, so allow a full purge plus the emit sequence
   localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 8;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int PHASES         = 5;
   localparam int ITEMS_PER_PHASE = 336;

   // command codes the block does not define; they are acknowledged and otherwise ignored
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   // traffic mixes for the random bursts
   localparam int MIX_FILL  = 0;
   localparam int MIX_DRAIN = 1;
   localparam int MIX_EVEN  = 2;

   localparam logic [CSR_ADDR_W-1:0] FLUSH_CODE_ADDR = {CSR_IDX_FLUSH_CODE, 2'b00};
   localparam entry_type NO_MSG = '0;

   // per-phase idling: percent of cycles the sender idles and the receiver stalls
   localparam int SEND_IDLE_PCT[PHASES]   = '{0, 80, 0, 13, 0};
   localparam int RSP_STALL_PCT[PHASES]   = '{0, 0, 80, 13, 0};
   localparam logic [15:0] PHASE_CODE[PHASES] = '{16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'h0000};
   localparam int HOLDOFF_PHASE = 4;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // stimulus backlog, queue model and expected results
   req_type   cmd_backlog[$];
   rsp_type   expected_rsps[$];
   entry_type held_msgs[$];
   bit        q_aborted   = 1'b1;
   bit        get_pending = 1'b0;
   logic [15:0] flush_code_r = '0;

   int  n_errors      = 0;
   int  cycle_count   = 0;
   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   int  holdoff_asked   = 0;
   int  holdoff_started = 0;
   int  holdoff_left    = 0;
   bit  req_fired = 1'b0;
   rsp_type rsp_want;

   message_fifo_with_abort_and_purge_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------------------
   // Queue model
   // ---------------------------------------------------------------------------------------

   // Queue one result; the count is always the one left after the whole command.
   function automatic void post_result(input reply_kind_type kind, input status_type st,
                                       input entry_type msg, input bit is_last);
      rsp_type r;
      r.reply_kind     = kind;
      r.status         = st;
      r.msg_code_out   = msg.code;
      r.first_arg_out  = msg.first;
      r.second_arg_out = msg.second;
      r.queued_count   = 7'(held_msgs.size());
      r.last           = is_last;
      expected_rsps.push_back(r);
   endfunction

   // Put and start share this: hand to a waiting get, refuse when full, else append.
   function automatic void offer_message(input entry_type msg);
      if (get_pending) begin
         get_pending = 1'b0;
         post_result(KIND_ACK, ST_OK, NO_MSG, 1'b0);
         post_result(KIND_DELIVER, ST_OK, msg, 1'b1);
      end else if (held_msgs.size() >= QUEUE_DEPTH) begin
         post_result(KIND_ACK, ST_FULL, NO_MSG, 1'b1);
      end else begin
         held_msgs.push_back(msg);
         post_result(KIND_ACK, ST_OK, NO_MSG, 1'b1);
      end
   endfunction

   function automatic void apply_command(input req_type c);
      entry_type msg;
      entry_type kept[$];
      msg.code   = c.msg_code;
      msg.first  = c.first_arg;
      msg.second = c.second_arg;
      case (c.cmd)
         CMD_PUT: begin
            if (q_aborted) post_result(KIND_ACK, ST_ABORTED, NO_MSG, 1'b1);
            else offer_message(msg);
         end
         CMD_GET: begin
            if (q_aborted) begin
               post_result(KIND_ACK, ST_ABORTED, NO_MSG, 1'b1);
            end else if (get_pending) begin
               post_result(KIND_ACK, ST_PENDING, NO_MSG, 1'b1);
            end else if (held_msgs.size() != 0) begin
               msg = held_msgs.pop_front();
               post_result(KIND_ACK, ST_OK, msg, 1'b1);
            end else if (c.wait_if_empty) begin
               // park the get; nothing comes back until a put, start or abort
               get_pending = 1'b1;
            end else begin
               post_result(KIND_ACK, ST_EMPTY, NO_MSG, 1'b1);
            end
         end
         CMD_FLUSH: begin
            held_msgs.delete();
            post_result(KIND_ACK, ST_OK, NO_MSG, 1'b1);
         end
         CMD_REMOVE: begin
            // purge every message of the code, keep the rest in order
            if (!q_aborted) begin
               foreach (held_msgs[i]) begin
                  if (held_msgs[i].code != c.msg_code) kept.push_back(held_msgs[i]);
               end
               held_msgs = kept;
            end
            post_result(KIND_ACK, ST_OK, NO_MSG, 1'b1);
         end
         CMD_ABORT: begin
            q_aborted = 1'b1;
            if (get_pending) begin
               get_pending = 1'b0;
               post_result(KIND_ACK, ST_OK, NO_MSG, 1'b0);
               post_result(KIND_DELIVER, ST_ABORTED, NO_MSG, 1'b1);
            end else begin
               post_result(KIND_ACK, ST_OK, NO_MSG, 1'b1);
            end
         end
         CMD_START: begin
            q_aborted  = 1'b0;
            msg.code   = flush_code_r;
            msg.first  = '0;
            msg.second = '0;
            offer_message(msg);
         end
         default: post_result(KIND_ACK, ST_OK, NO_MSG, 1'b1);
      endcase
   endfunction

   function automatic void check_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic req_type make_cmd(input logic [2:0] op, input logic [15:0] code,
                                        input logic [31:0] a1, input logic [31:0] a2,
                                        input logic wait_flag);
      req_type c;
      c.cmd           = op;
      c.msg_code      = code;
      c.first_arg     = a1;
      c.second_arg    = a2;
      c.wait_if_empty = wait_flag;
      return c;
   endfunction

   // Favor the extremes now and then, otherwise any 32-bit value.
   function automatic logic [31:0] pick_arg();
      case ($urandom_range(11))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly a small pool of codes so that removes actually hit something.
   function automatic logic [15:0] pick_code();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return 16'($urandom_range(7));
         5: return flush_code_r;
         6: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_cmd(input int mix);
      int put_w;
      int get_w;
      int r;
      logic [2:0] op;
      put_w = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 35;
      get_w = (mix == MIX_FILL) ? 20 : (mix == MIX_DRAIN) ? 62 : 35;
      r = $urandom_range(99);
      if (r < put_w) begin
         op = CMD_PUT;
      end else if (r < put_w + get_w) begin
         op = CMD_GET;
      end else begin
         case ($urandom_range(15))
            0, 1, 2, 3, 4: op = CMD_REMOVE;
            5, 6, 7, 8:    op = CMD_START;
            9, 10:         op = CMD_ABORT;
            11, 12:        op = CMD_FLUSH;
            13:            op = CMD_SPARE_6;
            14:            op = CMD_SPARE_7;
            default:       op = CMD_GET;
         endcase
      end
      return make_cmd(op, pick_code(), pick_arg(), pick_arg(), 1'($urandom_range(1)));
   endfunction

   // Bursts of biased traffic, plus now and then a run that fills the queue to the brim
   // and pushes past it.
   function automatic void queue_random_cmds(input int n);
      int made;
      int burst;
      int roll;
      int mix;
      made = 0;
      while (made < n) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            cmd_backlog.push_back(make_cmd(CMD_FLUSH, pick_code(), pick_arg(), pick_arg(), 1'b0));
            cmd_backlog.push_back(make_cmd(CMD_START, pick_code(), pick_arg(), pick_arg(), 1'b0));
            repeat (QUEUE_DEPTH + 2) begin
               cmd_backlog.push_back(make_cmd(CMD_PUT, pick_code(), pick_arg(), pick_arg(),
                                              1'($urandom_range(1))));
            end
            cmd_backlog.push_back(make_cmd(CMD_START, pick_code(), pick_arg(), pick_arg(), 1'b0));
            cmd_backlog.push_back(make_cmd(CMD_REMOVE, pick_code(), pick_arg(), pick_arg(), 1'b0));
            made += QUEUE_DEPTH + 6;
         end else begin
            mix   = (roll < 45) ? MIX_FILL : (roll < 75) ? MIX_DRAIN : MIX_EVEN;
            burst = $urandom_range(8, 24);
            repeat (burst) cmd_backlog.push_back(random_cmd(mix));
            made += burst;
         end
      end
   endfunction

   // Hold off until the backlog is out, every result is back and the block has settled.
   task automatic wait_until_drained();
      while (cmd_backlog.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the flush code (setup then access), then read it back.
   task automatic write_flush_code(input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= FLUSH_CODE_ADDR;
      pwdata  <= {16'h0000, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      flush_code_r = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'h0000, value}) begin
         n_errors++;
         $display("%0t: flush_code readback mismatch: expected %0h, actual %0h",
                  $time, value, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: advance to the next command only once the current one has been taken
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= cmd_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, forced high for the whole of a hold-off
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (holdoff_left > 0) || ($urandom_range(99) < stall_pct);
   end

   // Hold-off counter: start a long stall when one is asked for, count it down
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_started != holdoff_asked) begin
         holdoff_left    <= HOLDOFF_CYCLES;
         holdoff_started <= holdoff_asked;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: predict on each accepted command, check each accepted result in order
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_valid && !req_stall;
         if (req_fired) apply_command(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               n_errors++;
               $display("%0t: result with nothing expected: expected none, actual %p",
                        $time, rsp_data);
            end else begin
               rsp_want = expected_rsps.pop_front();
               check_field("reply_kind", 32'(rsp_want.reply_kind), 32'(rsp_data.reply_kind));
               check_field("status", 32'(rsp_want.status), 32'(rsp_data.status));
               check_field("msg_code_out", 32'(rsp_want.msg_code_out),
                           32'(rsp_data.msg_code_out));
               check_field("first_arg_out", rsp_want.first_arg_out, rsp_data.first_arg_out);
               check_field("second_arg_out", rsp_want.second_arg_out, rsp_data.second_arg_out);
               check_field("queued_count", 32'(rsp_want.queued_count),
                           32'(rsp_data.queued_count));
               check_field("last", 32'(rsp_want.last), 32'(rsp_data.last));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, expected_rsps.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence: reset, directed commands, then the random phases with a new flush code each
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [15:0] code_now;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_flush_code(16'hffff);

      // queue comes up aborted: put, get and remove are all refused or ignored
      cmd_backlog.push_back(make_cmd(CMD_PUT, 16'h0001, 32'h1, 32'h2, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b1));
      cmd_backlog.push_back(make_cmd(CMD_REMOVE, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_FLUSH, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_ABORT, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_SPARE_6, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
      cmd_backlog.push_back(make_cmd(CMD_SPARE_7, 16'h0000, 32'h0, 32'h0, 1'b0));
      // start opens the queue and enqueues the flush-code message
      cmd_backlog.push_back(make_cmd(CMD_START, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_PUT, 16'hffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_PUT, 16'h0000, 32'h0000_0000, 32'hffff_ffff, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b0));
      // purge the top code, then take what is left
      cmd_backlog.push_back(make_cmd(CMD_REMOVE, 16'hffff, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_REMOVE, 16'h0000, 32'h0, 32'h0, 1'b0));
      // park a get, refuse a second one, deliver to it with a put
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b1));
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_PUT, 16'h1234, 32'h8000_0000, 32'h7fff_ffff, 1'b1));
      // park again; start delivers the flush-code message
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b1));
      cmd_backlog.push_back(make_cmd(CMD_START, 16'h0000, 32'h0, 32'h0, 1'b0));
      // park again; abort releases it as aborted
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b1));
      cmd_backlog.push_back(make_cmd(CMD_ABORT, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_START, 16'h0000, 32'h0, 32'h0, 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_PUT, 16'ha5a5, pick_arg(), pick_arg(), 1'b0));
      cmd_backlog.push_back(make_cmd(CMD_GET, 16'h0000, 32'h0, 32'h0, 1'b0));
      wait_until_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         // registers only change while the block is idle
         code_now = (phase == 1 || phase == 4) ? 16'($urandom) : PHASE_CODE[phase];
         write_flush_code(code_now);
         send_idle_pct = SEND_IDLE_PCT[phase];
         stall_pct     = RSP_STALL_PCT[phase];
         queue_random_cmds(ITEMS_PER_PHASE);
         // long receiver hold-off while the sender keeps offering, so the input backs up
         if (phase == HOLDOFF_PHASE) holdoff_asked = holdoff_asked + 1;
         wait_until_drained();
      end

      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
